>>> src/mcps_pkg.sv
// Shared types, widths, sequencer codes and control program for the capacity search.
package mcps_pkg;

    localparam int WEIGHT_W = 16;
    localparam int DAYS_W   = 11;
    localparam int CAP_W    = 26;
    localparam int STEP_W   = 3;
    localparam int COND_W   = 3;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [COND_W-1:0] cond_t;

    localparam step_t S_IDLE   = 3'd0;
    localparam step_t S_INIT   = 3'd1;
    localparam step_t S_TEST   = 3'd2;
    localparam step_t S_WALK   = 3'd3;
    localparam step_t S_DECIDE = 3'd4;
    localparam step_t S_DONE   = 3'd5;

    localparam cond_t C_ALWAYS   = 3'd0;
    localparam cond_t C_IN_LAST  = 3'd1;
    localparam cond_t C_BOUNDS   = 3'd2;
    localparam cond_t C_WALK_END = 3'd3;
    localparam cond_t C_OUT_FREE = 3'd4;

    typedef struct packed {
        logic  ready;
        logic  init;
        logic  start_probe;
        logic  walk;
        logic  decide;
        logic  emit;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_word_t;

    function automatic ctrl_word_t ctrl_rom(input step_t step);
        ctrl_word_t cw;
        cw = '0;
        unique case (step)
            S_IDLE:
            begin
                cw.ready  = 1'b1;
                cw.cond   = C_IN_LAST;
                cw.hold   = 1'b1;
                cw.target = S_INIT;
            end
            S_INIT:
            begin
                cw.init   = 1'b1;
                cw.cond   = C_ALWAYS;
                cw.target = S_TEST;
            end
            S_TEST:
            begin
                cw.start_probe = 1'b1;
                cw.cond        = C_BOUNDS;
                cw.target      = S_DONE;
            end
            S_WALK:
            begin
                cw.walk   = 1'b1;
                cw.cond   = C_WALK_END;
                cw.hold   = 1'b1;
                cw.target = S_DECIDE;
            end
            S_DECIDE:
            begin
                cw.decide = 1'b1;
                cw.cond   = C_ALWAYS;
                cw.target = S_TEST;
            end
            S_DONE:
            begin
                cw.emit   = 1'b1;
                cw.cond   = C_OUT_FREE;
                cw.hold   = 1'b1;
                cw.target = S_IDLE;
            end
            default:
            begin
                cw.cond   = C_ALWAYS;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> src/min_capacity_partition_search.sv
// Top level of the minimum shipping capacity search with its microcoded sequencer.
// Weights are taken one item per cycle and written to an internal store; an item
// flagged is_last starts a binary search between the heaviest weight and the total,
// and the block takes no new item until the result has been placed in the output
// register. Each probe walks the stored weights through the single read port of the
// store, and the search makes about log2(total - heaviest + 1) probes, with a setup
// step before them and a hand-over step after them. Items beyond MAX_PACKAGES are
// dropped. The store needs no clearing after reset.
module min_capacity_partition_search #(
    parameter int MAX_PACKAGES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mcps_pkg::WEIGHT_W-1:0] package_weight,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mcps_pkg::CAP_W-1:0]    min_capacity
);

    localparam int CNT_W  = $clog2(MAX_PACKAGES + 1);
    localparam int ADDR_W = (MAX_PACKAGES > 1) ? $clog2(MAX_PACKAGES) : 1;
    localparam int TOT_W  = mcps_pkg::WEIGHT_W + CNT_W;
    localparam int CMP_W  = (CNT_W > mcps_pkg::DAYS_W) ? CNT_W : mcps_pkg::DAYS_W;
    localparam int EXT_W  = (TOT_W > mcps_pkg::CAP_W) ? TOT_W : mcps_pkg::CAP_W;

    logic [mcps_pkg::WEIGHT_W-1:0] weight_store_reg [MAX_PACKAGES];
    logic [mcps_pkg::WEIGHT_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]             raddr;

    mcps_pkg::step_t               step_reg, step_next;
    mcps_pkg::ctrl_word_t          cw;
    logic                          cond_true;

    logic [mcps_pkg::DAYS_W-1:0]   days_limit_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [TOT_W-1:0]              total_reg;
    logic [mcps_pkg::WEIGHT_W-1:0] heaviest_reg;
    logic [TOT_W-1:0]              lo_reg, hi_reg, mid_reg, load_reg;
    logic [CNT_W-1:0]              days_reg;
    logic [ADDR_W-1:0]             rd_idx_reg, proc_idx_reg;
    logic                          out_valid_reg;
    logic [mcps_pkg::CAP_W-1:0]    out_cap_reg;

    logic                          accept, store_we, emit, over, fits, walk_end;
    logic [TOT_W-1:0]              sum, mid_calc;
    logic [EXT_W-1:0]              lo_ext;

    assign cw       = mcps_pkg::ctrl_rom(step_reg);
    assign in_ready = cw.ready;
    assign accept   = in_valid && in_ready;
    assign store_we = accept && (count_reg < CNT_W'(MAX_PACKAGES));

    assign sum      = load_reg + TOT_W'(rdata_reg);
    assign over     = sum > mid_reg;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign fits     = CMP_W'(days_reg) <= CMP_W'(days_limit_reg);
    assign walk_end = CNT_W'(proc_idx_reg) == (count_reg - CNT_W'(1));
    assign lo_ext   = EXT_W'(lo_reg);
    assign raddr    = cw.start_probe ? '0 : rd_idx_reg;

    always_comb
    begin
        unique case (cw.cond)
            mcps_pkg::C_ALWAYS:   cond_true = 1'b1;
            mcps_pkg::C_IN_LAST:  cond_true = accept && is_last;
            mcps_pkg::C_BOUNDS:   cond_true = lo_reg >= hi_reg;
            mcps_pkg::C_WALK_END: cond_true = walk_end;
            mcps_pkg::C_OUT_FREE: cond_true = !out_valid_reg || out_ready;
            default:              cond_true = 1'b0;
        endcase
    end

    assign emit = cw.emit && cond_true;

    always_comb
    begin
        priority if (cond_true)
            step_next = cw.target;
        else if (cw.hold)
            step_next = step_reg;
        else
            step_next = mcps_pkg::STEP_W'(step_reg + mcps_pkg::STEP_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            weight_store_reg[count_reg[ADDR_W-1:0]] <= package_weight;
        rdata_reg <= weight_store_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= mcps_pkg::S_IDLE;
            days_limit_reg <= mcps_pkg::DAYS_W'(1);
            count_reg      <= '0;
            total_reg      <= '0;
            heaviest_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (psel && penable && pwrite && (paddr == 2'd0))
                days_limit_reg <= pwdata[mcps_pkg::DAYS_W-1:0];
            if (emit)
            begin
                count_reg    <= '0;
                total_reg    <= '0;
                heaviest_reg <= '0;
            end
            else if (store_we)
            begin
                count_reg <= CNT_W'(count_reg + CNT_W'(1));
                total_reg <= total_reg + TOT_W'(package_weight);
                if (package_weight > heaviest_reg)
                    heaviest_reg <= package_weight;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.init)
        begin
            lo_reg <= TOT_W'(heaviest_reg);
            hi_reg <= total_reg;
        end
        if (cw.start_probe)
        begin
            mid_reg      <= mid_calc;
            load_reg     <= '0;
            days_reg     <= CNT_W'(1);
            rd_idx_reg   <= ADDR_W'(1);
            proc_idx_reg <= '0;
        end
        if (cw.walk)
        begin
            load_reg     <= over ? TOT_W'(rdata_reg) : sum;
            if (over)
                days_reg <= CNT_W'(days_reg + CNT_W'(1));
            rd_idx_reg   <= ADDR_W'(rd_idx_reg + ADDR_W'(1));
            proc_idx_reg <= ADDR_W'(proc_idx_reg + ADDR_W'(1));
        end
        if (cw.decide)
        begin
            if (fits)
                hi_reg <= mid_reg;
            else
                lo_reg <= mid_reg + TOT_W'(1);
        end
        if (emit)
            out_cap_reg <= lo_ext[mcps_pkg::CAP_W-1:0];
    end

    assign out_valid    = out_valid_reg;
    assign min_capacity = out_cap_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == 2'd0) ? 32'(days_limit_reg) : 32'd0;

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == mcps_pkg::S_WALK) |-> (CNT_W'(proc_idx_reg) < count_reg))
        else $error("Probe walk runs past the stored items.");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == mcps_pkg::S_WALK || step_reg == mcps_pkg::S_DECIDE)
        |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("Probe capacity lies outside the search bounds.");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == '0) && (total_reg == '0) && out_valid_reg)
        else $error("Set not cleared after the result was issued.");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> !in_ready && (step_reg == mcps_pkg::S_INIT))
        else $error("Final item did not start the search.");

endmodule
